// File: rtl/mmh_pkg.sv
package mmh_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [31:0] MixC1 = 32'hcc9e2d51;
  localparam logic [31:0] MixC2 = 32'h1b873593;
  localparam logic [31:0] MixN  = 32'he6546b64;
  localparam logic [31:0] FinC1 = 32'h85ebca6b;
  localparam logic [31:0] FinC2 = 32'hc2b2ae35;

  localparam logic [2:0] FullCount = 3'd4;

  // scrambled word on its way from the front end to the hash update
  typedef struct packed {
    logic [31:0] k;
    logic [2:0]  cnt;
    logic        last;
  } item_t;

endpackage

// File: rtl/murmur3_32_hash_core.sv
// MurmurHash3 x86_32 engine.
// Input queue side: drive data_word_i (little-endian, first byte in 7:0),
// byte_count_i and last_i with push_i; a transfer happens when push_i is
// high and full_o is low. Words before the last always count as 4 bytes;
// a message ends with a last word of 0 to 4 bytes.
// Result queue side: hash_value_o is valid while empty_o is low and is
// taken when pop_i is high.
// The seed is written through cfg_we_i/cfg_seed_i between messages; each
// message starts from the seed held when its first word reaches the hash update.
// Throughput: one word per cycle while the result side does not stall;
// after each last word the hash unit takes no words during its FIN1 and
// FIN2 states, which run the two finalization multiplies. A last word
// reaches the result side through the first scramble stage (loaded at
// the transfer edge), the second scramble stage, the word queue, the
// hash update and two finalization stages.
// Reset clears the pipeline, queue, running state and seed (to zero).
// A stalled result holds in the output register; the hash unit and then
// the word queue back up, and full_o rises once the front stages fill.
module murmur3_32_hash_core import mmh_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_seed_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [31:0] hash_value_o
);

  logic [31:0] seed_q;
  logic        q_push, q_full, q_pop, q_empty;
  item_t       q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_seed_i;
    end
  end

  mmh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .full_o       (full_o),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (q_in)
  );

  mmh_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  mmh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_item_i     (q_out),
    .q_pop_o      (q_pop),
    .seed_i       (seed_q),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .hash_value_o (hash_value_o)
  );

endmodule

// File: rtl/mmh_front.sv
module mmh_front import mmh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  output logic        full_o,
  input  logic        q_full_i,
  output logic        q_push_o,
  output item_t       q_item_o
);

  logic        v1_q, v2_q;
  logic [31:0] p1_q, p2_q;
  logic [2:0]  cnt1_q, cnt2_q;
  logic        last1_q, last2_q;

  logic        s1_ready, s2_ready, accept;
  logic [2:0]  cnt_norm;
  logic [31:0] mask, masked, prod1, rot1, prod2;

  assign s2_ready = !v2_q || !q_full_i;
  assign s1_ready = !v1_q || s2_ready;
  assign full_o   = !s1_ready;
  assign accept   = push_i && s1_ready;

  // anything but a last word counts as four bytes
  assign cnt_norm = (!last_i || byte_count_i > FullCount) ? FullCount : byte_count_i;

  always_comb begin
    unique case (cnt_norm)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign masked = data_word_i & mask;
  assign prod1  = masked * MixC1;
  assign rot1   = {p1_q[16:0], p1_q[31:17]};
  assign prod2  = rot1 * MixC2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        v1_q <= push_i;
      end
      if (s2_ready) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_q    <= prod1;
      cnt1_q  <= cnt_norm;
      last1_q <= last_i;
    end
    if (s2_ready && v1_q) begin
      p2_q    <= prod2;
      cnt2_q  <= cnt1_q;
      last2_q <= last1_q;
    end
  end

  assign q_push_o      = v2_q && !q_full_i;
  assign q_item_o.k    = p2_q;
  assign q_item_o.cnt  = cnt2_q;
  assign q_item_o.last = last2_q;

endmodule

// File: rtl/mmh_fifo.sv
module mmh_fifo import mmh_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] DepthCnt = CW'(Depth);

  item_t         mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// File: rtl/mmh_back.sv
module mmh_back import mmh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  input  logic [31:0] seed_i,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [31:0] hash_value_o
);

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_FIN1 = 3'b010,
    ST_FIN2 = 3'b100
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] h_q, h_d, total_q, total_d, f_q, f_d, out_q, out_d;
  logic        mid_q, mid_d, out_v_q, out_v_d;

  logic        take;
  logic [31:0] h_base, tot_base, hx, rot, h_upd;
  logic [31:0] g, g2, e, fin_prod;

  assign take     = (state_q == ST_RUN) && !q_empty_i;
  assign q_pop_o  = take;
  assign h_base   = mid_q ? h_q : seed_i;
  assign tot_base = mid_q ? total_q : 32'd0;
  assign hx       = h_base ^ q_item_i.k;
  assign rot      = {hx[18:0], hx[31:19]};

  always_comb begin
    if (q_item_i.cnt == FullCount) begin
      h_upd = {rot[29:0], 2'b00} + rot + MixN;
    end else if (q_item_i.cnt != 3'd0) begin
      h_upd = hx;
    end else begin
      h_upd = h_base;
    end
  end

  assign g        = h_q ^ total_q;
  assign g2       = g ^ {16'd0, g[31:16]};
  assign e        = f_q ^ {13'd0, f_q[31:13]};
  assign fin_prod = e * FinC2;

  always_comb begin
    state_d = state_q;
    h_d     = h_q;
    total_d = total_q;
    mid_d   = mid_q;
    f_d     = f_q;
    out_d   = out_q;
    out_v_d = out_v_q && !pop_i;
    unique case (state_q)
      ST_RUN: begin
        if (take) begin
          h_d     = h_upd;
          total_d = tot_base + {29'd0, q_item_i.cnt};
          mid_d   = !q_item_i.last;
          if (q_item_i.last) begin
            state_d = ST_FIN1;
          end
        end
      end
      ST_FIN1: begin
        f_d     = g2 * FinC1;
        state_d = ST_FIN2;
      end
      ST_FIN2: begin
        if (!out_v_q || pop_i) begin
          out_d   = fin_prod ^ {16'd0, fin_prod[31:16]};
          out_v_d = 1'b1;
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      h_q     <= '0;
      total_q <= '0;
      mid_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
      total_q <= total_d;
      mid_q   <= mid_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q   <= f_d;
    out_q <= out_d;
  end

  assign empty_o      = !out_v_q;
  assign hash_value_o = out_q;

endmodule

// File: rtl/mmh_checker.sv
module mmh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push_i,
  input logic        full_o,
  input logic        pop_i,
  input logic        empty_o,
  input logic [31:0] hash_value_o
);

  // reset leaves both sides idle once it has been seen at an edge
  a_reset_idle: assert property (@(posedge clk_i)
    (!rst_ni ##1 !rst_ni) |-> (empty_o && !full_o))
    else $error("queues not idle in reset");

  // result holds until transferred
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(hash_value_o)))
    else $error("result dropped or changed while stalled");

  // output register only drains through a transfer
  a_drain_by_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty_o) |-> $past(pop_i))
    else $error("result lost without transfer");

  // front stage only fills through a transfer
  a_full_by_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_o) |-> $past(push_i))
    else $error("full raised without input transfer");

endmodule

bind murmur3_32_hash_core mmh_checker u_mmh_checker (.*);
